@@ rtl/mnes_pkg.sv @@
// mnes_pkg: shared types, constants and duration table for the note event sequencer
// no dependencies
package mnes_pkg;

   localparam int MAX_TRACKS_DEF       = 4;
   localparam int EVENTS_PER_TRACK_DEF = 2048;
   localparam int VOICES_PER_TRACK     = 4;
   localparam int NOTE_LIMIT           = 16;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_LENGTH = 2'd1;
   localparam logic [1:0] MODE_START  = 2'd2;
   localparam logic [1:0] MODE_TICK   = 2'd3;

   localparam logic [7:0] CMD_REST  = 8'h80;
   localparam logic [7:0] CMD_INSTR = 8'h81;
   localparam logic [7:0] CMD_VOL   = 8'h84;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ACK, ST_TRACK, ST_FETCH, ST_EVAL, ST_EMIT, ST_MARK
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // take the input beat
      logic do_write;    // event store write
      logic do_length;   // track length write
      logic do_start;    // rewind tracks in use
      logic trk_clear;   // track index to zero
      logic trk_next;    // advance track index
      logic fetch;       // read event word at position
      logic eval;        // apply fetched event
      logic count_down;  // decrement countdown
      logic emit;        // load note result
      logic emit_ack;    // load acknowledge / marker
      logic done_mark;   // marker carries song_done
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] mode;
      logic       playing;
      logic       trk_last;   // current track is last in use
      logic       no_tracks;
      logic       trk_active; // position below length
      logic       cnt_zero;
      logic       walk_end;   // event ends the walk (after eval)
      logic       note_ok;    // evaluated event emits a note
      logic       out_busy;
   } status_type;

   function automatic logic [9:0] duration(input logic [5:0] idx);
      logic [9:0] v;
      case (idx)
         6'd0: v = 10'd384;  6'd1: v = 10'd192;  6'd2: v = 10'd96;  6'd3: v = 10'd48;
         6'd4: v = 10'd24;   6'd5: v = 10'd12;   6'd6: v = 10'd6;   6'd7: v = 10'd3;
         6'd8: v = 10'd576;  6'd9: v = 10'd288;  6'd10: v = 10'd144; 6'd11: v = 10'd72;
         6'd12: v = 10'd36;  6'd13: v = 10'd18;  6'd14: v = 10'd9;  6'd15: v = 10'd4;
         6'd16: v = 10'd256; 6'd17: v = 10'd128; 6'd18: v = 10'd64; 6'd19: v = 10'd32;
         6'd20: v = 10'd16;  6'd21: v = 10'd8;   6'd22: v = 10'd4;  6'd23: v = 10'd2;
         6'd24: v = 10'd384; 6'd25: v = 10'd192; 6'd26: v = 10'd96; 6'd27: v = 10'd48;
         6'd28: v = 10'd24;  6'd29: v = 10'd12;  6'd30: v = 10'd6;  6'd31: v = 10'd3;
         6'd32: v = 10'd320; 6'd33: v = 10'd160; 6'd34: v = 10'd80; 6'd35: v = 10'd40;
         6'd36: v = 10'd20;  6'd37: v = 10'd10;  6'd38: v = 10'd5;  6'd39: v = 10'd2;
         6'd40: v = 10'd480; 6'd41: v = 10'd240; 6'd42: v = 10'd120; 6'd43: v = 10'd60;
         6'd44: v = 10'd30;  6'd45: v = 10'd15;  6'd46: v = 10'd7;  6'd47: v = 10'd3;
         6'd48: v = 10'd329; 6'd49: v = 10'd164; 6'd50: v = 10'd82; 6'd51: v = 10'd41;
         6'd52: v = 10'd20;  6'd53: v = 10'd10;  6'd54: v = 10'd5;  6'd55: v = 10'd2;
         6'd56: v = 10'd493; 6'd57: v = 10'd246; 6'd58: v = 10'd123; 6'd59: v = 10'd61;
         6'd60: v = 10'd30;  6'd61: v = 10'd15;  6'd62: v = 10'd7;  6'd63: v = 10'd3;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/mnes_ctrl.sv @@
// mnes_ctrl: sequencing state machine for the note event sequencer
// depends on mnes_pkg
module mnes_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mnes_pkg::status_type  stat,
   output mnes_pkg::cmd_type     cmd
);

   mnes_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mnes_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mnes_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = mnes_pkg::ST_ACK;
            end
         end
         mnes_pkg::ST_ACK: begin
            // act on the captured beat
            case (stat.mode)
               mnes_pkg::MODE_WRITE:  cmd.do_write  = 1'b1;
               mnes_pkg::MODE_LENGTH: cmd.do_length = 1'b1;
               mnes_pkg::MODE_START:  cmd.do_start  = 1'b1;
               default: ;
            endcase
            if (stat.mode == mnes_pkg::MODE_TICK && stat.playing) begin
               cmd.trk_clear = 1'b1;
               state_in = stat.no_tracks ? mnes_pkg::ST_MARK : mnes_pkg::ST_TRACK;
            end else begin
               state_in = mnes_pkg::ST_MARK;
            end
         end
         mnes_pkg::ST_TRACK: begin
            if (stat.trk_active && stat.cnt_zero) begin
               state_in = mnes_pkg::ST_FETCH;
            end else begin
               cmd.count_down = stat.trk_active;
               cmd.trk_next = 1'b1;
               state_in = stat.trk_last ? mnes_pkg::ST_MARK : mnes_pkg::ST_TRACK;
            end
         end
         mnes_pkg::ST_FETCH: begin
            if (!stat.trk_active) begin
               cmd.trk_next = 1'b1;
               state_in = stat.trk_last ? mnes_pkg::ST_MARK : mnes_pkg::ST_TRACK;
            end else begin
               cmd.fetch = 1'b1;
               state_in = mnes_pkg::ST_EVAL;
            end
         end
         mnes_pkg::ST_EVAL: begin
            if (stat.note_ok) begin
               if (!stat.out_busy) begin
                  cmd.eval = 1'b1;
                  cmd.emit = 1'b1;
                  state_in = mnes_pkg::ST_EMIT;
               end
            end else begin
               cmd.eval = 1'b1;
               state_in = mnes_pkg::ST_EMIT;
            end
         end
         mnes_pkg::ST_EMIT: begin
            // walk_end reflects the event just applied
            if (stat.walk_end) begin
               cmd.trk_next = 1'b1;
               state_in = stat.trk_last ? mnes_pkg::ST_MARK : mnes_pkg::ST_TRACK;
            end else begin
               state_in = mnes_pkg::ST_FETCH;
            end
         end
         mnes_pkg::ST_MARK: begin
            if (!stat.out_busy) begin
               cmd.emit_ack  = 1'b1;
               cmd.done_mark = (stat.mode == mnes_pkg::MODE_TICK) && stat.playing;
               state_in = mnes_pkg::ST_IDLE;
            end
         end
         default: state_in = mnes_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == mnes_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_capture_ack: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == mnes_pkg::ST_ACK)
      else $error("capture not followed by ack");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_ack) |-> !stat.out_busy)
      else $error("result overwrite");
`endif

endmodule

@@ rtl/mnes_dp.sv @@
// mnes_dp: event store, per-track state and result register
// depends on mnes_pkg
module mnes_dp #(
   parameter int MAX_TRACKS       = mnes_pkg::MAX_TRACKS_DEF,
   parameter int EVENTS_PER_TRACK = mnes_pkg::EVENTS_PER_TRACK_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mnes_pkg::cmd_type    cmd,
   output mnes_pkg::status_type stat,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_write_data,
   input  logic [1:0]           req_mode,
   input  logic [1:0]           req_track,
   input  logic [10:0]          req_position,
   input  logic [7:0]           req_command_byte,
   input  logic [7:0]           req_argument_byte,
   input  logic [11:0]          req_event_count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_note_valid,
   output logic [3:0]           rsp_voice,
   output logic [6:0]           rsp_note,
   output logic [7:0]           rsp_instrument,
   output logic [7:0]           rsp_volume,
   output logic                 rsp_last,
   output logic                 rsp_song_done
);

   localparam int TW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int PW    = $clog2(EVENTS_PER_TRACK);
   localparam int LW    = PW + 1;
   localparam int DEPTH = MAX_TRACKS * EVENTS_PER_TRACK;
   localparam int AW    = TW + PW;
   localparam int CW    = (MAX_TRACKS < 4) ? 3 : $clog2(MAX_TRACKS + 1);

   logic [15:0] mem [DEPTH];
   logic [15:0] word_ff;

   logic [2:0]    count_ff;
   logic [1:0]    mode_ff;
   logic [1:0]    trkin_ff;
   logic [10:0]   pos_in_ff;
   logic [15:0]   wdata_ff;
   logic [11:0]   cnt_ff;
   logic          playing_ff;
   logic [TW-1:0] trk_ff;
   logic [1:0]    chord_ff;
   logic [4:0]    notes_ff;
   logic          end_ff;

   logic [LW-1:0] len_ff [MAX_TRACKS];
   logic [LW-1:0] rpos_ff [MAX_TRACKS];
   logic [9:0]    tick_ff [MAX_TRACKS];
   logic [7:0]    inst_ff [MAX_TRACKS];
   logic [7:0]    vol_ff [MAX_TRACKS];

   logic          out_v_ff;
   logic          o_note_ff, o_last_ff, o_done_ff;
   logic [3:0]    o_voice_ff;
   logic [6:0]    o_noteno_ff;
   logic [7:0]    o_inst_ff, o_vol_ff;

   // tracks in use, saturated
   logic [CW-1:0] n_use;
   always_comb begin
      if ({{(CW > 3 ? CW - 3 : 0){1'b0}}, count_ff} > CW'(MAX_TRACKS)) begin
         n_use = CW'(MAX_TRACKS);
      end else begin
         n_use = CW'(count_ff);
      end
   end

   logic [7:0] c_b, d_b;
   logic       is_note, chord_drop;
   assign c_b = word_ff[15:8];
   assign d_b = word_ff[7:0];
   assign is_note    = !c_b[7];
   assign chord_drop = is_note && (chord_ff == 2'd3) && d_b[7];

   logic all_done;
   always_comb begin
      all_done = 1'b1;
      for (int t = 0; t < MAX_TRACKS; t++) begin
         if (CW'(t) < n_use && rpos_ff[t] < len_ff[t]) all_done = 1'b0;
      end
   end

   // status
   always_comb begin
      stat.mode       = mode_ff;
      stat.playing    = playing_ff;
      stat.trk_last   = ({{(CW > TW ? CW - TW : 0){1'b0}}, trk_ff} + CW'(1)) >= n_use;
      stat.no_tracks  = (n_use == '0);
      stat.trk_active = rpos_ff[trk_ff] < len_ff[trk_ff];
      stat.cnt_zero   = (tick_ff[trk_ff] == 10'd0);
      stat.walk_end   = end_ff;
      stat.note_ok    = is_note && !chord_drop && (notes_ff < 5'(mnes_pkg::NOTE_LIMIT));
      stat.out_busy   = out_v_ff;
   end

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd4;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         trkin_ff  <= req_track;
         pos_in_ff <= req_position;
         wdata_ff  <= {req_command_byte, req_argument_byte};
         cnt_ff    <= req_event_count;
      end
   end

   // event store
   always_ff @(posedge clock) begin
      if (cmd.do_write && 32'(trkin_ff) < 32'(MAX_TRACKS)
          && 32'(pos_in_ff) < 32'(EVENTS_PER_TRACK)) begin
         mem[AW'({TW'(trkin_ff), PW'(pos_in_ff)})] <= wdata_ff;
      end
      if (cmd.fetch) begin
         word_ff <= mem[{trk_ff, rpos_ff[trk_ff][PW-1:0]}];
      end
   end

   // walk control
   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         trk_ff     <= '0;
         chord_ff   <= '0;
         notes_ff   <= '0;
         end_ff     <= 1'b0;
      end else begin
         if (cmd.do_start) playing_ff <= 1'b1;
         if (cmd.trk_clear) begin
            trk_ff   <= '0;
            notes_ff <= '0;
            chord_ff <= '0;
         end else if (cmd.trk_next) begin
            trk_ff   <= trk_ff + TW'(1);
            chord_ff <= '0;
         end
         if (cmd.eval) begin
            // a rest or an unflagged note closes the walk
            end_ff <= (c_b == mnes_pkg::CMD_REST) || (is_note && !chord_drop && !d_b[7]);
            if (is_note && !chord_drop) begin
               if (d_b[7]) chord_ff <= chord_ff + 2'd1;
               if (stat.note_ok) notes_ff <= notes_ff + 5'd1;
            end
         end
      end
   end

   // per-track state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < MAX_TRACKS; t++) begin
            len_ff[t]  <= '0;
            rpos_ff[t] <= '0;
            tick_ff[t] <= '0;
            inst_ff[t] <= '0;
            vol_ff[t]  <= 8'd127;
         end
      end else begin
         if (cmd.do_length && 32'(trkin_ff) < 32'(MAX_TRACKS)) begin
            if (32'(cnt_ff) > 32'(EVENTS_PER_TRACK)) begin
               len_ff[trkin_ff[TW-1:0]] <= LW'(EVENTS_PER_TRACK);
            end else begin
               len_ff[trkin_ff[TW-1:0]] <= LW'(cnt_ff);
            end
         end
         if (cmd.do_start) begin
            for (int t = 0; t < MAX_TRACKS; t++) begin
               if (CW'(t) < n_use) begin
                  rpos_ff[t] <= '0;
                  inst_ff[t] <= 8'(t);
                  vol_ff[t]  <= 8'd127;
                  tick_ff[t] <= '0;
               end
            end
         end
         if (cmd.count_down) tick_ff[trk_ff] <= tick_ff[trk_ff] - 10'd1;
         if (cmd.fetch) rpos_ff[trk_ff] <= rpos_ff[trk_ff] + LW'(1);
         if (cmd.eval) begin
            if (c_b == mnes_pkg::CMD_REST) begin
               tick_ff[trk_ff] <= mnes_pkg::duration(d_b[5:0]);
            end else if (c_b == mnes_pkg::CMD_INSTR) begin
               if (d_b != 8'd0) inst_ff[trk_ff] <= d_b - 8'd1;
            end else if (c_b == mnes_pkg::CMD_VOL) begin
               vol_ff[trk_ff] <= d_b;
            end else if (is_note && !chord_drop) begin
               tick_ff[trk_ff] <= mnes_pkg::duration(d_b[5:0]);
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_ack) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_note_ff   <= 1'b1;
         o_voice_ff  <= 4'({trk_ff, chord_ff});
         o_noteno_ff <= c_b[6:0];
         o_inst_ff   <= inst_ff[trk_ff];
         o_vol_ff    <= vol_ff[trk_ff];
         o_last_ff   <= 1'b0;
         o_done_ff   <= 1'b0;
      end else if (cmd.emit_ack) begin
         o_note_ff   <= 1'b0;
         o_voice_ff  <= '0;
         o_noteno_ff <= '0;
         o_inst_ff   <= '0;
         o_vol_ff    <= '0;
         o_last_ff   <= 1'b1;
         o_done_ff   <= cmd.done_mark && all_done;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_note_valid = o_note_ff;
   assign rsp_voice      = o_voice_ff;
   assign rsp_note       = o_noteno_ff;
   assign rsp_instrument = o_inst_ff;
   assign rsp_volume     = o_vol_ff;
   assign rsp_last       = o_last_ff;
   assign rsp_song_done  = o_done_ff;

`ifndef SYNTHESIS
   a_note_budget: assert property (@(posedge clock) disable iff (reset)
      notes_ff <= 5'(mnes_pkg::NOTE_LIMIT))
      else $error("note budget exceeded");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_voice))
      else $error("result dropped");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_song_done |-> rsp_last)
      else $error("song_done off marker");
`endif

endmodule

@@ rtl/multitrack_note_event_sequencer.sv @@
// multitrack note event sequencer: one item in flight at a time; write, length and
// start items pass through the idle, ack and mark states; a tick visits each track in use
// in turn and reads its due events one by one in the serial event walk;
// results wait in one output register and each waiting result stalls the walk
// synchronous active-high reset clears track state, volume to 127 and track_count to 4;
// event store contents are undefined until written
// top level: joins mnes_ctrl and mnes_dp, uses mnes_pkg
module multitrack_note_event_sequencer #(
   parameter int MAX_TRACKS       = mnes_pkg::MAX_TRACKS_DEF,
   parameter int EVENTS_PER_TRACK = mnes_pkg::EVENTS_PER_TRACK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_track,
   input  logic [10:0] req_position,
   input  logic [7:0]  req_command_byte,
   input  logic [7:0]  req_argument_byte,
   input  logic [11:0] req_event_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_note_valid,
   output logic [3:0]  rsp_voice,
   output logic [6:0]  rsp_note,
   output logic [7:0]  rsp_instrument,
   output logic [7:0]  rsp_volume,
   output logic        rsp_last,
   output logic        rsp_song_done
);

   mnes_pkg::cmd_type    cmd;
   mnes_pkg::status_type stat;

   // sequencing
   mnes_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat(stat), .cmd(cmd)
   );

   // storage and results
   mnes_dp #(.MAX_TRACKS(MAX_TRACKS), .EVENTS_PER_TRACK(EVENTS_PER_TRACK)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_mode(req_mode), .req_track(req_track), .req_position(req_position),
      .req_command_byte(req_command_byte), .req_argument_byte(req_argument_byte),
      .req_event_count(req_event_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_note_valid(rsp_note_valid),
      .rsp_voice(rsp_voice), .rsp_note(rsp_note), .rsp_instrument(rsp_instrument),
      .rsp_volume(rsp_volume), .rsp_last(rsp_last), .rsp_song_done(rsp_song_done)
   );

endmodule
